[rtl/chd_pkg.sv]
// Shared types, widths and constants of the core hotplug decider.
package chd_pkg;

   localparam int LANES      = 4;
   localparam int LANE_IDX_W = 2;
   localparam int FREQ_W     = 22;
   localparam int TIME_W     = 48;
   localparam int MASK_W     = 4;
   localparam int PCT_W      = 7;
   localparam int CNT_W      = 4;
   localparam int CORE_W     = 3;
   localparam int PACE_W     = 8;
   localparam int Q_W        = 16;
   localparam int LIM_W      = 23;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;

   // Division by 100 is a multiply by a truncated reciprocal followed by a
   // single correction step.
   localparam int          DIV_SHIFT = 30;
   localparam int          RECIP_W   = 24;
   localparam int          PROD_W    = FREQ_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((64'd1 << DIV_SHIFT) / 100);
   localparam int          DIVISOR   = 100;

   localparam int DEF_CORES           = 4;
   localparam int DEF_BOOST_WINDOW_US = 500000;
   localparam int DEF_INPUT_GAP_US    = 150000;
   localparam int DEF_SCREENOFF_CORES = 2;

   localparam logic [CORE_W-1:0] RST_MIN_ONLINE  = 3'd1;
   localparam logic [PCT_W-1:0]  RST_UP_PCT      = 7'd80;
   localparam logic [PCT_W-1:0]  RST_DOWN_PCT    = 7'd60;
   localparam logic [PACE_W-1:0] RST_TICKS_UP    = 8'd1;
   localparam logic [PACE_W-1:0] RST_TICKS_DOWN  = 8'd2;
   localparam logic [CORE_W-1:0] RST_BOOST_CORES = 3'd2;
   localparam logic [FREQ_W-1:0] RST_BOOST_MIN   = 22'd1497600;

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_USER       = 2'd1,
      OP_SCREEN_OFF = 2'd2,
      OP_RSVD       = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_UP    = 2'd1,
      ACT_DOWN  = 2'd2,
      ACT_BOOST = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_MAX_ONLINE   = 3'd0,
      REG_MIN_ONLINE   = 3'd1,
      REG_UP_PCT       = 3'd2,
      REG_DOWN_PCT     = 3'd3,
      REG_TICKS_UP     = 3'd4,
      REG_TICKS_DOWN   = 3'd5,
      REG_BOOST_CORES  = 3'd6,
      REG_BOOST_MIN    = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [CNT_W-1:0]  max_online;
      logic [CORE_W-1:0] min_online;
      logic [PCT_W-1:0]  up_percent;
      logic [PCT_W-1:0]  down_percent;
      logic [PACE_W-1:0] ticks_before_up;
      logic [PACE_W-1:0] ticks_before_down;
      logic [CORE_W-1:0] boost_cores;
      logic [FREQ_W-1:0] boost_min_freq;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic [TIME_W-1:0]            now_us;
      logic [MASK_W-1:0]            online_mask;
      logic [FREQ_W-1:0]            max_freq;
      logic [LANES-1:0][FREQ_W-1:0] freq;
   } item_type;

   // What one core lane reports to the merge stage.
   typedef struct packed {
      logic             vis;
      logic             on;
      logic             gt_up;
      logic             lt_down;
      logic             ge_boost;
      logic [LANES-1:0] le;
   } lane_res_type;

endpackage

[rtl/chd_if.sv]
// Valid/ready channel interfaces for decision requests and responses.
interface chd_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [chd_pkg::TIME_W-1:0]  now_us;
   logic [chd_pkg::MASK_W-1:0]  online_mask;
   logic [chd_pkg::FREQ_W-1:0]  max_freq;
   logic [chd_pkg::FREQ_W-1:0]  freq_core0;
   logic [chd_pkg::FREQ_W-1:0]  freq_core1;
   logic [chd_pkg::FREQ_W-1:0]  freq_core2;
   logic [chd_pkg::FREQ_W-1:0]  freq_core3;

   modport source (
      output valid, opcode, now_us, online_mask, max_freq,
             freq_core0, freq_core1, freq_core2, freq_core3,
      input  ready
   );
   modport sink (
      input  valid, opcode, now_us, online_mask, max_freq,
             freq_core0, freq_core1, freq_core2, freq_core3,
      output ready
   );
endinterface

interface chd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  action;
   logic [chd_pkg::MASK_W-1:0]  target_mask;

   modport source (output valid, action, target_mask, input ready);
   modport sink (input valid, action, target_mask, output ready);
endinterface

[rtl/chd_csr.sv]
// Configuration register file with limit clamping and APB-style access.
module chd_csr #(
   parameter int CORES = chd_pkg::DEF_CORES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [chd_pkg::ADDR_W-1:0]   paddr,
   input  logic [chd_pkg::DATA_W-1:0]   pwdata,
   output logic [chd_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output chd_pkg::cfg_type             cfg
);

   localparam logic [chd_pkg::CNT_W-1:0] CORES_N = chd_pkg::CNT_W'(CORES);

   logic [chd_pkg::CNT_W-1:0]  max_online_ff, max_online_in, max_sel, max_clamp;
   logic [chd_pkg::CORE_W-1:0] min_online_ff, min_online_in, min_sel, min_clamp;
   logic [chd_pkg::PCT_W-1:0]  up_pct_ff, up_pct_in, down_pct_ff, down_pct_in;
   logic [chd_pkg::PACE_W-1:0] ticks_up_ff, ticks_up_in, ticks_down_ff, ticks_down_in;
   logic [chd_pkg::CORE_W-1:0] boost_cores_ff, boost_cores_in;
   logic [chd_pkg::FREQ_W-1:0] boost_min_ff, boost_min_in;
   logic                       wr;
   chd_pkg::reg_idx_type       idx;
   logic [chd_pkg::CORE_W-1:0] wdata3;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = chd_pkg::reg_idx_type'(paddr[4:2]);
   assign wdata3 = pwdata[chd_pkg::CORE_W-1:0];

   // The limits are clamped after every write to one of the first six
   // registers: max first, then min against the new max.
   always_comb begin
      max_sel = (idx == chd_pkg::REG_MAX_ONLINE) ? chd_pkg::CNT_W'(wdata3) : max_online_ff;
      min_sel = (idx == chd_pkg::REG_MIN_ONLINE) ? wdata3 : min_online_ff;
      if (max_sel == '0) begin
         max_clamp = chd_pkg::CNT_W'(1);
      end else if (max_sel > CORES_N) begin
         max_clamp = CORES_N;
      end else begin
         max_clamp = max_sel;
      end
      if (min_sel == '0) begin
         min_clamp = chd_pkg::CORE_W'(1);
      end else if (chd_pkg::CNT_W'(min_sel) > max_clamp) begin
         min_clamp = chd_pkg::CORE_W'(max_clamp);
      end else begin
         min_clamp = min_sel;
      end
   end

   always_comb begin
      max_online_in  = max_online_ff;
      min_online_in  = min_online_ff;
      up_pct_in      = up_pct_ff;
      down_pct_in    = down_pct_ff;
      ticks_up_in    = ticks_up_ff;
      ticks_down_in  = ticks_down_ff;
      boost_cores_in = boost_cores_ff;
      boost_min_in   = boost_min_ff;
      if (wr) begin
         unique case (idx)
            chd_pkg::REG_MAX_ONLINE, chd_pkg::REG_MIN_ONLINE: begin
               max_online_in = max_clamp;
               min_online_in = min_clamp;
            end
            chd_pkg::REG_UP_PCT: begin
               up_pct_in     = pwdata[chd_pkg::PCT_W-1:0];
               max_online_in = max_clamp;
               min_online_in = min_clamp;
            end
            chd_pkg::REG_DOWN_PCT: begin
               down_pct_in   = pwdata[chd_pkg::PCT_W-1:0];
               max_online_in = max_clamp;
               min_online_in = min_clamp;
            end
            chd_pkg::REG_TICKS_UP: begin
               ticks_up_in   = pwdata[chd_pkg::PACE_W-1:0];
               max_online_in = max_clamp;
               min_online_in = min_clamp;
            end
            chd_pkg::REG_TICKS_DOWN: begin
               ticks_down_in = pwdata[chd_pkg::PACE_W-1:0];
               max_online_in = max_clamp;
               min_online_in = min_clamp;
            end
            chd_pkg::REG_BOOST_CORES: begin
               if (wdata3 != '0 && chd_pkg::CNT_W'(wdata3) <= CORES_N) begin
                  boost_cores_in = wdata3;
               end
            end
            chd_pkg::REG_BOOST_MIN: begin
               boost_min_in = pwdata[chd_pkg::FREQ_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_online_ff  <= CORES_N;
         min_online_ff  <= chd_pkg::RST_MIN_ONLINE;
         up_pct_ff      <= chd_pkg::RST_UP_PCT;
         down_pct_ff    <= chd_pkg::RST_DOWN_PCT;
         ticks_up_ff    <= chd_pkg::RST_TICKS_UP;
         ticks_down_ff  <= chd_pkg::RST_TICKS_DOWN;
         boost_cores_ff <= chd_pkg::RST_BOOST_CORES;
         boost_min_ff   <= chd_pkg::RST_BOOST_MIN;
      end else begin
         max_online_ff  <= max_online_in;
         min_online_ff  <= min_online_in;
         up_pct_ff      <= up_pct_in;
         down_pct_ff    <= down_pct_in;
         ticks_up_ff    <= ticks_up_in;
         ticks_down_ff  <= ticks_down_in;
         boost_cores_ff <= boost_cores_in;
         boost_min_ff   <= boost_min_in;
      end
   end

   always_comb begin
      unique case (idx)
         chd_pkg::REG_MAX_ONLINE:  prdata = chd_pkg::DATA_W'(max_online_ff);
         chd_pkg::REG_MIN_ONLINE:  prdata = chd_pkg::DATA_W'(min_online_ff);
         chd_pkg::REG_UP_PCT:      prdata = chd_pkg::DATA_W'(up_pct_ff);
         chd_pkg::REG_DOWN_PCT:    prdata = chd_pkg::DATA_W'(down_pct_ff);
         chd_pkg::REG_TICKS_UP:    prdata = chd_pkg::DATA_W'(ticks_up_ff);
         chd_pkg::REG_TICKS_DOWN:  prdata = chd_pkg::DATA_W'(ticks_down_ff);
         chd_pkg::REG_BOOST_CORES: prdata = chd_pkg::DATA_W'(boost_cores_ff);
         chd_pkg::REG_BOOST_MIN:   prdata = chd_pkg::DATA_W'(boost_min_ff);
         default:                  prdata = '0;
      endcase
   end

   assign cfg.max_online        = max_online_ff;
   assign cfg.min_online        = min_online_ff;
   assign cfg.up_percent        = up_pct_ff;
   assign cfg.down_percent      = down_pct_ff;
   assign cfg.ticks_before_up   = ticks_up_ff;
   assign cfg.ticks_before_down = ticks_down_ff;
   assign cfg.boost_cores       = boost_cores_ff;
   assign cfg.boost_min_freq    = boost_min_ff;

endmodule

[rtl/chd_lane.sv]
// One core lane: compares its core's frequency with the limits and the other cores.
module chd_lane #(
   parameter int IDX   = 0,
   parameter int CORES = chd_pkg::DEF_CORES
) (
   input  logic                                          clock,
   input  logic                                          advance,
   input  logic [chd_pkg::LANES-1:0][chd_pkg::FREQ_W-1:0] freq,
   input  logic [chd_pkg::MASK_W-1:0]                    online_mask,
   input  logic [chd_pkg::LIM_W-1:0]                     up_lim,
   input  logic [chd_pkg::LIM_W-1:0]                     down_lim,
   input  logic [chd_pkg::FREQ_W-1:0]                    min_boost,
   output chd_pkg::lane_res_type                         res
);

   localparam int VIS     = (CORES < chd_pkg::LANES) ? CORES : chd_pkg::LANES;
   localparam bit VISIBLE = (IDX < VIS);

   chd_pkg::lane_res_type res_ff, res_in;
   logic [chd_pkg::FREQ_W-1:0] own;

   assign own = freq[IDX];

   always_comb begin
      res_in.vis      = VISIBLE;
      // Core 0 counts as online whatever its mask bit says.
      res_in.on       = (IDX == 0) ? 1'b1 : (VISIBLE && online_mask[IDX]);
      res_in.gt_up    = chd_pkg::LIM_W'(own) > up_lim;
      res_in.lt_down  = chd_pkg::LIM_W'(own) < down_lim;
      res_in.ge_boost = own >= min_boost;
      for (int d = 0; d < chd_pkg::LANES; d++) begin
         res_in.le[d] = own <= freq[d];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

[rtl/chd_merge.sv]
// Merge stage: combines the lane results, makes the decision and holds the policy state.
module chd_merge #(
   parameter int BOOST_WINDOW_US = chd_pkg::DEF_BOOST_WINDOW_US,
   parameter int INPUT_GAP_US    = chd_pkg::DEF_INPUT_GAP_US,
   parameter int SCREENOFF_CORES = chd_pkg::DEF_SCREENOFF_CORES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic [1:0]                           opcode,
   input  logic [chd_pkg::TIME_W-1:0]           now_us,
   input  chd_pkg::lane_res_type [chd_pkg::LANES-1:0] lanes,
   input  chd_pkg::cfg_type                     cfg,
   output logic                                 rsp_valid,
   output logic [1:0]                           action,
   output logic [chd_pkg::MASK_W-1:0]           target_mask
);

   localparam logic [chd_pkg::TIME_W-1:0] WINDOW = chd_pkg::TIME_W'(BOOST_WINDOW_US);
   localparam logic [chd_pkg::TIME_W-1:0] GAP    = chd_pkg::TIME_W'(INPUT_GAP_US);
   localparam logic [chd_pkg::CNT_W-1:0]  SCR_N  = chd_pkg::CNT_W'(SCREENOFF_CORES);
   localparam logic [chd_pkg::PACE_W-1:0] PACE_MAX = '1;

   logic                               rsp_valid_ff;
   chd_pkg::action_type                action_ff, action_in;
   logic [chd_pkg::MASK_W-1:0]         target_ff, target_in;
   logic [chd_pkg::PACE_W-1:0]         pace_ff, pace_in;
   logic [chd_pkg::TIME_W-1:0]         boost_time_ff, boost_time_in;

   logic                               have_slow, found_off, slow_is_core0;
   logic [chd_pkg::LANE_IDX_W-1:0]     slow_idx, fast_idx;
   logic [chd_pkg::CNT_W-1:0]          n_online, n_left;
   logic [chd_pkg::MASK_W-1:0]         low_off, scr_mask;
   logic                               slow_gt_up, fast_ge_boost, fast_lt_down;
   logic                               pace_clear;
   logic [chd_pkg::TIME_W-1:0]         since;
   logic [chd_pkg::CNT_W-1:0]          max_n, min_n, boost_n;

   // Running slowest and fastest core over the online cores above core 0.
   // A core at or below the running slowest rate never updates the fastest.
   always_comb begin
      have_slow = 1'b0;
      slow_idx  = '0;
      fast_idx  = '0;
      for (int c = 1; c < chd_pkg::LANES; c++) begin
         if (lanes[c].on) begin
            if (!have_slow || lanes[c].le[slow_idx]) begin
               slow_idx  = chd_pkg::LANE_IDX_W'(c);
               have_slow = 1'b1;
            end else if (!lanes[c].le[fast_idx]) begin
               fast_idx = chd_pkg::LANE_IDX_W'(c);
            end
         end
      end
      slow_is_core0 = !have_slow || !lanes[slow_idx].le[0];
      slow_gt_up    = slow_is_core0 ? lanes[0].gt_up : lanes[slow_idx].gt_up;
      fast_ge_boost = lanes[fast_idx].ge_boost;
      fast_lt_down  = lanes[fast_idx].lt_down;
   end

   always_comb begin
      n_online  = '0;
      low_off   = '0;
      found_off = 1'b0;
      for (int c = 0; c < chd_pkg::LANES; c++) begin
         n_online = n_online + chd_pkg::CNT_W'(lanes[c].on);
      end
      for (int c = 1; c < chd_pkg::LANES; c++) begin
         if (!found_off && lanes[c].vis && !lanes[c].on) begin
            low_off[c] = 1'b1;
            found_off  = 1'b1;
         end
      end
   end

   // Screen off drops online cores from core 1 upward until the limit is met.
   always_comb begin
      scr_mask = '0;
      n_left   = n_online;
      for (int c = 1; c < chd_pkg::LANES; c++) begin
         if (lanes[c].on && n_left > SCR_N) begin
            scr_mask[c] = 1'b1;
            n_left      = n_left - chd_pkg::CNT_W'(1);
         end
      end
   end

   assign since   = now_us - boost_time_ff;
   assign max_n   = cfg.max_online;
   assign min_n   = chd_pkg::CNT_W'(cfg.min_online);
   assign boost_n = chd_pkg::CNT_W'(cfg.boost_cores);

   always_comb begin
      action_in     = chd_pkg::ACT_NONE;
      target_in     = '0;
      pace_clear    = 1'b0;
      pace_in       = pace_ff;
      boost_time_in = boost_time_ff;
      unique case (chd_pkg::opcode_type'(opcode))
         chd_pkg::OP_TICK: begin
            if (slow_gt_up && fast_ge_boost) begin
               if (n_online < max_n && pace_ff >= cfg.ticks_before_up) begin
                  action_in  = chd_pkg::ACT_UP;
                  target_in  = low_off;
                  pace_clear = 1'b1;
               end
            end else if (n_online <= boost_n && since <= WINDOW) begin
               if (n_online < boost_n && n_online < max_n) begin
                  action_in = chd_pkg::ACT_UP;
                  target_in = low_off;
               end
            end else if (have_slow && fast_lt_down) begin
               if (n_online > min_n && pace_ff >= cfg.ticks_before_down) begin
                  action_in  = chd_pkg::ACT_DOWN;
                  target_in  = chd_pkg::MASK_W'(1) << slow_idx;
                  pace_clear = 1'b1;
               end
            end
            if (pace_clear) begin
               pace_in = chd_pkg::PACE_W'(1);
            end else if (pace_ff != PACE_MAX) begin
               pace_in = pace_ff + chd_pkg::PACE_W'(1);
            end
         end
         chd_pkg::OP_USER: begin
            if (since >= GAP && cfg.boost_cores > cfg.min_online) begin
               boost_time_in = now_us;
               action_in     = chd_pkg::ACT_BOOST;
            end
         end
         chd_pkg::OP_SCREEN_OFF: begin
            target_in = scr_mask;
            if (scr_mask != '0) begin
               action_in = chd_pkg::ACT_DOWN;
            end
         end
         chd_pkg::OP_RSVD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pace_ff       <= '0;
         boost_time_ff <= '0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid;
         if (in_valid) begin
            pace_ff       <= pace_in;
            boost_time_ff <= boost_time_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         action_ff <= action_in;
         target_ff <= target_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign action      = action_ff;
   assign target_mask = target_ff;

endmodule

[rtl/core_hotplug_decider_top.sv]
// Top level of the core hotplug decider: request pipeline, core lanes, merge and registers.
//
// The decider takes one request transfer per clock cycle when the response side keeps
// up, and returns exactly one response transfer for each, in order. A load tick
// derives the up and down limits as (max_freq / 100) * percent, compares every
// visible core against those limits and against each other in one lane per core,
// and then the merge stage picks the slowest and fastest online core and decides
// whether to bring the lowest offline core up, take the slowest core down, or hold
// cores up inside the boost window. A user input request arms the boost window,
// and a screen off request takes cores down to the screen off limit. The pipeline
// stages are a reciprocal multiply for the division by 100, its correction step,
// the percentage multiply, the lane compares, and the merge stage that owns the
// pacing counter and the boost time stamp. The whole pipeline moves as one; it
// stalls only while a finished response waits in the output register and the
// consumer is not ready, so requests keep flowing while the output is drained.
// Configuration writes go through the APB-style port and are expected only while
// no request is in flight.
module core_hotplug_decider_top #(
   parameter int CORES           = chd_pkg::DEF_CORES,
   parameter int BOOST_WINDOW_US = chd_pkg::DEF_BOOST_WINDOW_US,
   parameter int INPUT_GAP_US    = chd_pkg::DEF_INPUT_GAP_US,
   parameter int SCREENOFF_CORES = chd_pkg::DEF_SCREENOFF_CORES
) (
   input  logic                        clock,
   input  logic                        reset,
   chd_req_if.sink                     req_ch,
   chd_rsp_if.source                   rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [chd_pkg::ADDR_W-1:0]  paddr,
   input  logic [chd_pkg::DATA_W-1:0]  pwdata,
   output logic [chd_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   chd_pkg::cfg_type  cfg;
   chd_pkg::item_type in_item;
   logic              advance;
   logic              rsp_valid;

   // Stage 1 holds the raw product of max_freq and the reciprocal of 100.
   logic                               s1_valid_ff;
   chd_pkg::item_type                  s1_item_ff;
   logic [chd_pkg::PROD_W-1:0]         s1_prod_ff, prod_in;

   // Stage 2 holds the exact quotient max_freq / 100.
   logic                               s2_valid_ff;
   chd_pkg::item_type                  s2_item_ff;
   logic [chd_pkg::Q_W-1:0]            s2_q_ff, q_est, q_in;
   logic [chd_pkg::FREQ_W:0]           rem;

   // Stage 3 holds the scaled limits and the capped boost frequency.
   logic                               s3_valid_ff;
   chd_pkg::item_type                  s3_item_ff;
   logic [chd_pkg::LIM_W-1:0]          s3_up_ff, s3_down_ff, up_in, down_in;
   logic [chd_pkg::FREQ_W-1:0]         s3_boost_ff, boost_in;

   // Stage 4 holds the lane results (inside the lanes) and what the merge needs.
   logic                               s4_valid_ff;
   logic [1:0]                         s4_opcode_ff;
   logic [chd_pkg::TIME_W-1:0]         s4_now_ff;
   chd_pkg::lane_res_type [chd_pkg::LANES-1:0] lane_res;

   // The pipeline advances whenever the output register is empty or its
   // response is being transferred this cycle.
   assign advance      = !rsp_valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   assign in_item.opcode      = req_ch.opcode;
   assign in_item.now_us      = req_ch.now_us;
   assign in_item.online_mask = req_ch.online_mask;
   assign in_item.max_freq    = req_ch.max_freq;
   assign in_item.freq[0]     = req_ch.freq_core0;
   assign in_item.freq[1]     = req_ch.freq_core1;
   assign in_item.freq[2]     = req_ch.freq_core2;
   assign in_item.freq[3]     = req_ch.freq_core3;

   assign prod_in = chd_pkg::PROD_W'(req_ch.max_freq) * chd_pkg::PROD_W'(chd_pkg::RECIP_100);

   // The truncated reciprocal can land one below the true quotient; a single
   // remainder check fixes that.
   assign q_est = s1_prod_ff[chd_pkg::DIV_SHIFT +: chd_pkg::Q_W];
   assign rem   = (chd_pkg::FREQ_W+1)'(s1_item_ff.max_freq)
                - (chd_pkg::FREQ_W+1)'(q_est) * (chd_pkg::FREQ_W+1)'(chd_pkg::DIVISOR);
   assign q_in  = (rem >= (chd_pkg::FREQ_W+1)'(chd_pkg::DIVISOR))
                ? q_est + chd_pkg::Q_W'(1) : q_est;

   assign up_in    = chd_pkg::LIM_W'(s2_q_ff) * chd_pkg::LIM_W'(cfg.up_percent);
   assign down_in  = chd_pkg::LIM_W'(s2_q_ff) * chd_pkg::LIM_W'(cfg.down_percent);
   assign boost_in = (s2_item_ff.max_freq <= cfg.boost_min_freq)
                   ? s2_item_ff.max_freq : cfg.boost_min_freq;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_ch.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff   <= in_item;
         s1_prod_ff   <= prod_in;
         s2_item_ff   <= s1_item_ff;
         s2_q_ff      <= q_in;
         s3_item_ff   <= s2_item_ff;
         s3_up_ff     <= up_in;
         s3_down_ff   <= down_in;
         s3_boost_ff  <= boost_in;
         s4_opcode_ff <= s3_item_ff.opcode;
         s4_now_ff    <= s3_item_ff.now_us;
      end
   end

   for (genvar g = 0; g < chd_pkg::LANES; g++) begin : g_lane
      chd_lane #(
         .IDX   (g),
         .CORES (CORES)
      ) u_lane (
         .clock       (clock),
         .advance     (advance),
         .freq        (s3_item_ff.freq),
         .online_mask (s3_item_ff.online_mask),
         .up_lim      (s3_up_ff),
         .down_lim    (s3_down_ff),
         .min_boost   (s3_boost_ff),
         .res         (lane_res[g])
      );
   end

   chd_merge #(
      .BOOST_WINDOW_US (BOOST_WINDOW_US),
      .INPUT_GAP_US    (INPUT_GAP_US),
      .SCREENOFF_CORES (SCREENOFF_CORES)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s4_valid_ff),
      .opcode      (s4_opcode_ff),
      .now_us      (s4_now_ff),
      .lanes       (lane_res),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .action      (rsp_ch.action),
      .target_mask (rsp_ch.target_mask)
   );

   assign rsp_ch.valid = rsp_valid;

   chd_csr #(
      .CORES (CORES)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

endmodule

[bench/testbench.sv]
// Self-checking testbench for the core hotplug decider: stimulus, prediction and scoreboard.
import chd_pkg::*;

typedef struct packed {
   action_type       action;
   logic [MASK_W-1:0] target_mask;
} decision_type;

// Scoreboard: mirrors the registers and the pacing and boost state, and turns every
// request transfer into the decision that must come back for it.
class hotplug_scoreboard;
   int unsigned max_online, min_online, up_pct, down_pct;
   int unsigned ticks_up, ticks_down, boost_cores, boost_min;
   logic [PACE_W-1:0] pace_count;
   logic [TIME_W-1:0] boost_stamp;
   decision_type      pending[$];
   int                failures;

   function new();
      max_online  = DEF_CORES;
      min_online  = RST_MIN_ONLINE;
      up_pct      = RST_UP_PCT;
      down_pct    = RST_DOWN_PCT;
      ticks_up    = RST_TICKS_UP;
      ticks_down  = RST_TICKS_DOWN;
      boost_cores = RST_BOOST_CORES;
      boost_min   = RST_BOOST_MIN;
      pace_count  = '0;
      boost_stamp = '0;
      failures    = 0;
   endfunction

   function void write_reg(reg_idx_type idx, logic [DATA_W-1:0] value);
      case (idx)
         REG_MAX_ONLINE: max_online = value[2:0];
         REG_MIN_ONLINE: min_online = value[2:0];
         REG_UP_PCT:     up_pct     = value[6:0];
         REG_DOWN_PCT:   down_pct   = value[6:0];
         REG_TICKS_UP:   ticks_up   = value[7:0];
         REG_TICKS_DOWN: ticks_down = value[7:0];
         REG_BOOST_CORES: begin
            // Out-of-range core counts leave the old value in place.
            if (value[2:0] >= 1 && value[2:0] <= DEF_CORES) boost_cores = value[2:0];
         end
         REG_BOOST_MIN:  boost_min  = value[FREQ_W-1:0];
      endcase
      if (idx != REG_BOOST_CORES && idx != REG_BOOST_MIN) begin
         if (max_online < 1) max_online = 1;
         if (max_online > DEF_CORES) max_online = DEF_CORES;
         if (min_online < 1) min_online = 1;
         if (min_online > max_online) min_online = max_online;
      end
   endfunction

   function logic [MASK_W-1:0] first_offline(logic [MASK_W-1:0] online);
      first_offline = '0;
      for (int c = LANES - 1; c >= 1; c--)
         if (!online[c]) first_offline = MASK_W'(1) << c;
   endfunction

   function void note_request(item_type it);
      logic [MASK_W-1:0] online;
      int unsigned       n;
      logic [FREQ_W-1:0] maxf, slow, fast, min_boost;
      logic [63:0]       up_lim, down_lim;
      logic [TIME_W-1:0] since;
      int                slow_core;
      bit                have_slow;
      decision_type      d;
      online = {it.online_mask[MASK_W-1:1], 1'b1};
      n = $countones(online);
      since = it.now_us - boost_stamp;
      d.action = ACT_NONE;
      d.target_mask = '0;
      case (opcode_type'(it.opcode))
         OP_TICK: begin
            maxf = it.max_freq;
            up_lim = 64'(maxf / 22'd100) * 64'(up_pct);
            down_lim = 64'(maxf / 22'd100) * 64'(down_pct);
            fast = it.freq[0];
            slow = '0;
            slow_core = 0;
            have_slow = 1'b0;
            // A core at or below the running slowest never updates the fastest.
            for (int c = 1; c < LANES; c++) begin
               if (online[c]) begin
                  if (!have_slow || it.freq[c] <= slow) begin
                     slow_core = c;
                     slow = it.freq[c];
                     have_slow = 1'b1;
                  end else if (it.freq[c] > fast) begin
                     fast = it.freq[c];
                  end
               end
            end
            if (!have_slow || it.freq[0] < slow) slow = it.freq[0];
            min_boost = (maxf <= boost_min) ? maxf : FREQ_W'(boost_min);
            if (64'(slow) > up_lim && fast >= min_boost) begin
               if (n < max_online && pace_count >= ticks_up) begin
                  d.action = ACT_UP;
                  d.target_mask = first_offline(online);
                  pace_count = '0;
               end
            end else if (n <= boost_cores && since <= TIME_W'(DEF_BOOST_WINDOW_US)) begin
               if (n < boost_cores && n < max_online) begin
                  d.action = ACT_UP;
                  d.target_mask = first_offline(online);
               end
            end else if (slow_core != 0 && 64'(fast) < down_lim) begin
               if (n > min_online && pace_count >= ticks_down) begin
                  d.action = ACT_DOWN;
                  d.target_mask = MASK_W'(1) << slow_core;
                  pace_count = '0;
               end
            end
            if (pace_count != '1) pace_count++;
         end
         OP_USER: begin
            if (since >= TIME_W'(DEF_INPUT_GAP_US) && boost_cores > min_online) begin
               boost_stamp = it.now_us;
               d.action = ACT_BOOST;
            end
         end
         OP_SCREEN_OFF: begin
            for (int c = 1; c < LANES; c++) begin
               if (online[c] && n > DEF_SCREENOFF_CORES) begin
                  d.target_mask[c] = 1'b1;
                  n--;
               end
            end
            if (d.target_mask != '0) d.action = ACT_DOWN;
         end
         default: ;
      endcase
      pending.push_back(d);
   endfunction

   function void check_decision(action_type act, logic [MASK_W-1:0] target);
      decision_type want;
      if (pending.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected decision: action %0d target %b", act, target);
      end else begin
         want = pending.pop_front();
         if (want.action != act || want.target_mask != target) begin
            failures++;
            if (failures <= 10)
               $display("decision mismatch: expected action %0d target %b, got action %0d target %b",
                        want.action, want.target_mask, act, target);
         end
      end
   endfunction
endclass

module testbench;

   localparam int TICK_PHASE_ITEMS  = 400;
   localparam int OTHER_PHASE_ITEMS = 70;
   localparam int PHASES            = 8;
   localparam int HOLD_CYCLES       = 90;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Configuration port. It is driven to idle from the very start.
   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [ADDR_W-1:0] paddr   = '0;
   logic [DATA_W-1:0] pwdata  = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   chd_req_if req_ch ();
   chd_rsp_if rsp_ch ();

   hotplug_scoreboard board = new();

   // Shared between the sender and the receiver: calm turns all idling off, and
   // hold_request asks the receiver for one long hold-off.
   bit                calm = 1'b0;
   bit                hold_request = 1'b0;
   logic [TIME_W-1:0] sim_us;
   logic [FREQ_W-1:0] phase_maxf;
   item_type          taken;

   core_hotplug_decider_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Both channels are watched at the rising edge. A request transfer is handed
   // to the scoreboard for prediction, and a response transfer is checked
   // against the oldest outstanding decision.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            taken.opcode      = req_ch.opcode;
            taken.now_us      = req_ch.now_us;
            taken.online_mask = req_ch.online_mask;
            taken.max_freq    = req_ch.max_freq;
            taken.freq[0]     = req_ch.freq_core0;
            taken.freq[1]     = req_ch.freq_core1;
            taken.freq[2]     = req_ch.freq_core2;
            taken.freq[3]     = req_ch.freq_core3;
            board.note_request(taken);
         end
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_decision(action_type'(rsp_ch.action), rsp_ch.target_mask);
      end
   end

   // Response side. Ready drops at random about 15 percent of the time, never during a calm
   // phase, and for one long stretch whenever the sequencer asks for it. That
   // stretch is counted here in cycles so the sender keeps pushing requests
   // until the pipeline fills and back-pressure reaches the request channel.
   initial begin : drain_side
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (calm) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 15);
         end
      end
   end

   // One register write: a setup phase, then an access phase that completes at
   // the rising edge where pready is high. The mirror in the scoreboard is
   // updated at that same edge. A bus-idle phase follows so that psel never
   // falls and rises within one time step.
   task automatic write_reg(input reg_idx_type idx, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.write_reg(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Offers one request and returns at the falling edge after its transfer.
   // Outside calm phases the sender first idles now and then.
   task automatic offer(input opcode_type op, input logic [TIME_W-1:0] now,
                        input logic [MASK_W-1:0] mask, input logic [FREQ_W-1:0] maxf,
                        input logic [FREQ_W-1:0] f0, f1, f2, f3);
      if (!calm && $urandom_range(99) < 7) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op;
      req_ch.now_us      <= now;
      req_ch.online_mask <= mask;
      req_ch.max_freq    <= maxf;
      req_ch.freq_core0  <= f0;
      req_ch.freq_core1  <= f1;
      req_ch.freq_core2  <= f2;
      req_ch.freq_core3  <= f3;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drops valid and waits until every decision has come back, plus a margin
   // for the five-stage pipeline, so registers can be written safely.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // Random request. Most are load ticks with frequencies laid out relative to
   // the current maximum frequency, so that the up, down and boost paths are
   // all taken; time mostly moves forward in realistic steps, with occasional
   // jumps and wraps of the 48-bit microsecond counter.
   task automatic random_item();
      int                r, scen;
      opcode_type        op;
      logic [MASK_W-1:0] mask;
      logic [FREQ_W-1:0] maxf;
      logic [FREQ_W-1:0] f[LANES];
      logic [63:0]       pick, base;
      r = $urandom_range(99);
      if (r < 74)      op = OP_TICK;
      else if (r < 86) op = OP_USER;
      else if (r < 95) op = OP_SCREEN_OFF;
      else             op = OP_RSVD;
      r = $urandom_range(99);
      if (r < 55)      sim_us = sim_us + $urandom_range(40000);
      else if (r < 88) sim_us = sim_us + $urandom_range(600000);
      else if (r < 93) sim_us = TIME_W'({$urandom, $urandom});
      else if (r < 96) sim_us = '1 - TIME_W'($urandom_range(300000));
      mask = $urandom_range(15);
      r = $urandom_range(99);
      if (r < 80)      maxf = phase_maxf;
      else if (r < 88) maxf = FREQ_W'($urandom);
      else if (r < 94) maxf = '0;
      else             maxf = '1;
      scen = $urandom_range(4);
      for (int c = 0; c < LANES; c++) begin
         case (scen)
            0: pick = (64'(maxf) * $urandom_range(75, 100)) / 100;
            1: pick = (64'(maxf) * $urandom_range(0, 65)) / 100;
            2: pick = (64'(maxf) * $urandom_range(0, 100)) / 100;
            3: begin
               // Sit right on one of the thresholds, one below or one above.
               case ($urandom_range(3))
                  0: base = 64'(maxf / 22'd100) * board.up_pct;
                  1: base = 64'(maxf / 22'd100) * board.down_pct;
                  2: base = 64'(board.boost_min);
                  default: base = 64'(maxf);
               endcase
               pick = base + $urandom_range(2) - 1;
            end
            default: pick = 64'($urandom);
         endcase
         f[c] = pick[FREQ_W-1:0];
      end
      offer(op, sim_us, mask, maxf, f[0], f[1], f[2], f[3]);
   endtask

   // Register settings per phase: the low extremes first, then the high
   // extremes, then the reset values, then random settings written in a
   // rotated order so that the clamping of the core limits sees both orders.
   task automatic configure(input int phase);
      logic [DATA_W-1:0] v[8];
      int                start;
      case (phase)
         0: v = '{0, 0, 0, 0, 0, 0, 1, 0};
         1: v = '{7, 7, 100, 100, 255, 255, 4, 4194303};
         2: v = '{4, 1, 80, 60, 1, 2, 2, 1497600};
         default: begin
            v[REG_MAX_ONLINE]  = $urandom_range(4);
            v[REG_MIN_ONLINE]  = $urandom_range(4);
            v[REG_UP_PCT]      = $urandom_range(100);
            v[REG_DOWN_PCT]    = $urandom_range(100);
            v[REG_TICKS_UP]    = ($urandom_range(3) == 0) ? $urandom_range(255)
                                                          : $urandom_range(6);
            v[REG_TICKS_DOWN]  = ($urandom_range(3) == 0) ? $urandom_range(255)
                                                          : $urandom_range(6);
            v[REG_BOOST_CORES] = $urandom_range(5);
            v[REG_BOOST_MIN]   = ($urandom_range(1) == 0) ? $urandom_range(4194303)
                                                          : $urandom_range(800000, 2500000);
         end
      endcase
      start = (phase < 3) ? 0 : $urandom_range(7);
      for (int k = 0; k < 8; k++)
         write_reg(reg_idx_type'((start + k) % 8), v[(start + k) % 8]);
      // Out-of-range boost core counts must be ignored by the block.
      if (phase == 0) write_reg(REG_BOOST_CORES, 0);
      if (phase == 1) write_reg(REG_BOOST_CORES, 7);
   endtask

   initial begin : stimulus
      int count;
      req_ch.valid       <= 1'b0;
      req_ch.opcode      <= OP_TICK;
      req_ch.now_us      <= '0;
      req_ch.online_mask <= '0;
      req_ch.max_freq    <= '0;
      req_ch.freq_core0  <= '0;
      req_ch.freq_core1  <= '0;
      req_ch.freq_core2  <= '0;
      req_ch.freq_core3  <= '0;
      sim_us = TIME_W'(1000000);
      phase_maxf = 22'd2000000;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests under the reset settings. The boost time stamp starts
      // at zero, so the very first tick already sits inside the boost window.
      offer(OP_TICK, 0, 4'b0000, 0, 0, 0, 0, 0);
      offer(OP_USER, 100, 4'b0001, 0, 0, 0, 0, 0);
      // Every core busy but none left to add.
      offer(OP_TICK, 600000, 4'b1111, 2000000, 2000000, 2000000, 2000000, 2000000);
      offer(OP_TICK, 600010, 4'b0111, 2000000, 1900000, 1800000, 1700000, 1600000);
      // Light load: the first tick is held back by pacing, the second removes core 2.
      offer(OP_TICK, 600020, 4'b1111, 2000000, 300000, 200000, 100000, 200000);
      offer(OP_TICK, 600030, 4'b1111, 2000000, 300000, 200000, 100000, 200000);
      // Core 0 counts as online with its mask bit clear; a later core above the
      // slowest but below core 0 must not become the fastest.
      offer(OP_TICK, 600040, 4'b1110, 2000000, 1000000, 900000, 800000, 950000);
      offer(OP_TICK, 600050, 4'b1111, 2000000, 100, 500000, 400000, 1900000);
      offer(OP_RSVD, '1, 4'b1111, '1, '1, '1, '1, '1);
      // Screen off down to two cores, with and without anything to remove.
      offer(OP_SCREEN_OFF, 600060, 4'b1111, 0, 0, 0, 0, 0);
      offer(OP_SCREEN_OFF, 600070, 4'b0111, 0, 0, 0, 0, 0);
      offer(OP_SCREEN_OFF, 600080, 4'b0011, 0, 0, 0, 0, 0);
      offer(OP_SCREEN_OFF, 600090, 4'b1110, 0, 0, 0, 0, 0);
      // Arm the boost, try again too soon, then hold cores up inside the window.
      offer(OP_USER, 1000000, 4'b0001, 0, 0, 0, 0, 0);
      offer(OP_USER, 1000500, 4'b0001, 0, 0, 0, 0, 0);
      offer(OP_TICK, 1000600, 4'b0001, 2000000, 1000, 1000, 1000, 1000);
      offer(OP_TICK, 1000700, 4'b0011, 2000000, 1000, 1000, 1000, 1000);
      // Boost armed just before the time counter wraps; the window spans the wrap.
      offer(OP_USER, 48'hFFFF_FFFF_FFF0, 4'b0001, 0, 0, 0, 0, 0);
      offer(OP_TICK, 100, 4'b0001, 2000000, 1000, 1000, 1000, 1000);
      offer(OP_TICK, '1, 4'b1111, '1, '1, '1, '1, '1);
      // Maximum frequency below the boost minimum caps the boost requirement.
      offer(OP_TICK, 700000, 4'b0011, 1000000, 1000000, 1000000, 1000000, 1000000);
      offer(OP_TICK, 800000, 4'b1111, 0, 0, 0, 0, 0);
      settle();

      // Random phases. The high-extreme phase runs long enough for the pacing
      // counter to saturate, the reset-value phase runs without any idling, and
      // two of the random phases include a long hold-off on the response side.
      for (int phase = 0; phase < PHASES; phase++) begin
         configure(phase);
         phase_maxf = $urandom_range(300000, 4194303);
         calm = (phase == 2);
         count = (phase == 1) ? TICK_PHASE_ITEMS : OTHER_PHASE_ITEMS;
         for (int k = 0; k < count; k++) begin
            if ((phase == 4 || phase == 6) && k == 20) hold_request = 1'b1;
            random_item();
         end
         settle();
         calm = 1'b0;
      end

      board.failures += board.pending.size();
      if (board.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin
      #3000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
